>>> rtl/wmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared constants, types and helpers of the window median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int MAX_WINDOW  = 7;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int CELLS       = MAX_WINDOW * MAX_WINDOW;
  localparam int PIX_W       = 8;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W       = 3;
  localparam int RANK_W      = $clog2(CELLS);
  localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_WINDOW_SIZE  = 2'd2,
    REG_COLOR_MODE   = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctrl_t;

  // rank floor(ws*ws/2) of the window
  function automatic logic [RANK_W-1:0] median_rank(input logic [WIN_W-1:0] ws);
    logic [2*WIN_W-1:0] sq;
    sq = ws * ws;
    return RANK_W'(sq >> 1);
  endfunction

endpackage

`default_nettype wire

>>> rtl/window_median_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_median_filter_core
// Square-window median filter on a raster pixel stream, gray or three channel.
// ----------------------------------------------------------------------------
// One pixel at a time: each pixel is written to the line store; one that
// completes a ws x ws window is then sorted by reading the
// window out of the single read port of the line store, one sample a cycle,
// into a chain of sorting cells per channel. A result may wait in the output
// register while the next pixel is taken. Config writes are taken only between
// pixels, win over a pixel offered in the same cycle, and restart the frame.
module window_median_filter_core
  import wmf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PIX_W-1:0]  chan_a,
  input  wire logic [PIX_W-1:0]  chan_b,
  input  wire logic [PIX_W-1:0]  chan_c,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [PIX_W-1:0]  median_a,
  output logic      [PIX_W-1:0]  median_b,
  output logic      [PIX_W-1:0]  median_c,
  output logic                   row_end,
  output logic                   frame_end,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [ROW_W:0]    cfg_data
);

  // configuration
  logic [COL_W:0]   image_width;
  logic [ROW_W:0]   image_height;
  logic [WIN_W-1:0] window_size;
  logic             color_mode;

  state_t state, state_next;

  logic cfg_we;
  assign cfg_ready = (state == S_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= (COL_W+1)'(640);
      image_height <= (ROW_W+1)'(480);
      window_size  <= WIN_W'(3);
      color_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[COL_W:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_WINDOW_SIZE:  window_size  <= cfg_data[WIN_W-1:0];
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [COL_W:0]   w_eff;
  logic [ROW_W:0]   h_eff;
  logic [WIN_W-1:0] ws_eff;

  always_comb begin
    w_eff = image_width;
    if (image_width == '0) w_eff = (COL_W+1)'(1);
    else if (image_width > (COL_W+1)'(MAX_WIDTH)) w_eff = (COL_W+1)'(MAX_WIDTH);
    h_eff = image_height;
    if (image_height == '0) h_eff = (ROW_W+1)'(1);
    else if (image_height > (ROW_W+1)'(MAX_HEIGHT)) h_eff = (ROW_W+1)'(MAX_HEIGHT);
    ws_eff = (window_size == '0) ? WIN_W'(1) : window_size;
  end

  // position of the next pixel
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [SLOT_W-1:0] slot;

  logic   in_acc;
  assign in_acc = in_valid && in_ready;

  logic acc_last_col, acc_last_row, acc_emit;
  assign acc_last_col = ({1'b0, col} + (COL_W+1)'(1)) >= w_eff;
  assign acc_last_row = ({1'b0, row} + (ROW_W+1)'(1)) >= h_eff;
  assign acc_emit     = (({1'b0, row} + (ROW_W+1)'(1)) >= (ROW_W+1)'(ws_eff)) &&
                        (({1'b0, col} + (COL_W+1)'(1)) >= (COL_W+1)'(ws_eff));

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row  <= '0;
      col  <= '0;
      slot <= '0;
    end else if (in_acc) begin
      if (acc_last_col) begin
        col <= '0;
        if (acc_last_row) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + ROW_W'(1);
          slot <= (slot == SLOT_W'(MAX_WINDOW-1)) ? '0 : slot + SLOT_W'(1);
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // per-pixel working registers
  logic [3*PIX_W-1:0] pix;
  logic [ADDR_W-1:0]  wr_addr;
  logic               emit, last_col, last_row;
  logic [SLOT_W-1:0]  top_slot;
  logic [COL_W-1:0]   col_start;

  logic [SLOT_W:0] top_sum;
  logic [COL_W:0]  start_sum;
  assign top_sum   = (SLOT_W+1)'(slot) + (SLOT_W+1)'(MAX_WINDOW + 1) - (SLOT_W+1)'(ws_eff);
  assign start_sum = {1'b0, col} + (COL_W+1)'(1) - (COL_W+1)'(ws_eff);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix       <= color_mode ? {chan_c, chan_b, chan_a} : {{(2*PIX_W){1'b0}}, chan_a};
      wr_addr   <= ADDR_W'({slot, col});
      emit      <= acc_emit;
      last_col  <= acc_last_col;
      last_row  <= acc_last_row;
      top_slot  <= (top_sum >= (SLOT_W+1)'(MAX_WINDOW)) ?
                   SLOT_W'(top_sum - (SLOT_W+1)'(MAX_WINDOW)) : SLOT_W'(top_sum);
      col_start <= start_sum[COL_W-1:0];
    end
  end

  // window read-out
  logic [SLOT_W-1:0] rd_slot;
  logic [WIN_W-1:0]  dr, dc;
  logic              rd_last;
  logic              rd_valid_q;
  logic [COL_W-1:0]  rd_col;
  logic [3*PIX_W-1:0] rd_data;

  assign rd_last = (dr == ws_eff - WIN_W'(1)) && (dc == ws_eff - WIN_W'(1));
  assign rd_col  = col_start + COL_W'(dc);

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      rd_slot <= top_slot;
      dr      <= '0;
      dc      <= '0;
    end else if (state == S_READ) begin
      if (dc == ws_eff - WIN_W'(1)) begin
        dc      <= '0;
        dr      <= dr + WIN_W'(1);
        rd_slot <= (rd_slot == SLOT_W'(MAX_WINDOW-1)) ? '0 : rd_slot + SLOT_W'(1);
      end else begin
        dc <= dc + WIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= (state == S_READ);
    end
  end

  wmf_ram #(
    .WIDTH (3*PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (state == S_WRITE),
    .wr_addr (wr_addr),
    .wr_data (pix),
    .rd_en   (state == S_READ),
    .rd_addr (ADDR_W'({rd_slot, rd_col})),
    .rd_data (rd_data)
  );

  // sorters
  sort_ctrl_t        sort_ctrl;
  logic [RANK_W-1:0] rank;
  logic [PIX_W-1:0]  med_a, med_b, med_c;

  assign sort_ctrl.clear  = (state == S_WRITE);
  assign sort_ctrl.insert = rd_valid_q;
  assign rank             = median_rank(ws_eff);

  wmf_sorter u_sort_a (
    .clk (clk), .rst (rst), .ctrl (sort_ctrl),
    .din (rd_data[PIX_W-1:0]), .rank (rank), .median (med_a)
  );
  wmf_sorter u_sort_b (
    .clk (clk), .rst (rst), .ctrl (sort_ctrl),
    .din (rd_data[2*PIX_W-1:PIX_W]), .rank (rank), .median (med_b)
  );
  wmf_sorter u_sort_c (
    .clk (clk), .rst (rst), .ctrl (sort_ctrl),
    .din (rd_data[3*PIX_W-1:2*PIX_W]), .rank (rank), .median (med_c)
  );

  // sequencer
  logic out_free;
  logic out_load;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_acc) state_next = S_WRITE;
      S_WRITE: state_next = emit ? S_READ : S_IDLE;
      S_READ:  if (rd_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      // hold the pixel while a config write is offered
      S_IDLE:  in_ready = !cfg_valid;
      S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median_a  <= med_a;
      median_b  <= color_mode ? med_b : '0;
      median_c  <= color_mode ? med_c : '0;
      row_end   <= last_col;
      frame_end <= last_col && last_row;
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE))
    else $error("input taken outside idle");

  a_insert_window: assert property (@(posedge clk) disable iff (rst)
    sort_ctrl.insert |-> (state == S_READ || state == S_DRAIN))
    else $error("sorter insert outside window read-out");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (row == '0 && col == '0 && slot == '0))
    else $error("config write did not restart the frame");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

>>> rtl/wmf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/wmf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmf_cell
// One place of the insertion sorter: holds a sample, takes the new sample or
// its upper neighbour's sample when an insert lands at or above it.
// ----------------------------------------------------------------------------
module wmf_cell
  import wmf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sort_ctrl_t       ctrl,
  input  wire logic [PIX_W-1:0] din,
  input  wire logic [PIX_W-1:0] prev_value,
  input  wire logic             prev_valid,
  input  wire logic             prev_lt,
  output logic      [PIX_W-1:0] value,
  output logic                  valid,
  output logic                  lt
);

  // an empty place counts as larger than any sample
  assign lt = !valid || (din < value);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      valid <= valid | prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && lt) begin
      value <= prev_lt ? prev_value : din;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wmf_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmf_sorter
// Chain of sorting cells for one channel, with rank selection at the end.
// ----------------------------------------------------------------------------
module wmf_sorter
  import wmf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sort_ctrl_t        ctrl,
  input  wire logic [PIX_W-1:0]  din,
  input  wire logic [RANK_W-1:0] rank,
  output logic      [PIX_W-1:0]  median
);

  logic [PIX_W-1:0] value [CELLS];
  logic [CELLS-1:0] valid;
  logic [CELLS-1:0] lt;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic [PIX_W-1:0] pv;
    logic             pvld;
    logic             plt;
    if (i == 0) begin : g_head
      assign pv   = din;
      assign pvld = 1'b1;
      assign plt  = 1'b0;
    end else begin : g_body
      assign pv   = value[i-1];
      assign pvld = valid[i-1];
      assign plt  = lt[i-1];
    end
    wmf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .din        (din),
      .prev_value (pv),
      .prev_valid (pvld),
      .prev_lt    (plt),
      .value      (value[i]),
      .valid      (valid[i]),
      .lt         (lt[i])
    );
  end

  always_comb begin
    median = value[0];
    for (int k = 0; k < CELLS; k++) begin
      if (rank == RANK_W'(k)) begin
        median = value[k];
      end
    end
  end

endmodule

`default_nettype wire
